/* src/lobm_pkg.sv */
// shared types and codes for the order book matcher
package lobm_pkg;

    localparam logic [1:0] OP_NEW     = 2'd0;
    localparam logic [1:0] OP_PARTIAL = 2'd1;
    localparam logic [1:0] OP_TOTAL   = 2'd2;

    localparam logic [2:0] KIND_FILL      = 3'd0;
    localparam logic [2:0] KIND_RESTED    = 3'd1;
    localparam logic [2:0] KIND_FILLED    = 3'd2;
    localparam logic [2:0] KIND_CANCELED  = 3'd3;
    localparam logic [2:0] KIND_NOT_FOUND = 3'd4;
    localparam logic [2:0] KIND_FULL      = 3'd5;

    // controller to datapath
    typedef struct packed {
        logic load;        // capture the incoming beat
        logic scan_clear;  // start a scan
        logic scan_step;   // evaluate one slot
        logic scan_cancel; // never set; the scan matches by id for cancels, else by best price
        logic do_fill;     // trade against the best slot
        logic do_rest;     // write remainder into free slot
        logic do_cancel;   // apply cancel to found slot
        logic out_load;    // put a result into the output register
        logic [2:0] out_kind;
        logic out_last;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic found;
        logic has_free;
        logic rem_zero;
        logic [1:0] operation;
    } t_status;

endpackage

/* src/limit_order_book_matcher.sv */
// top level: limit order book with price-time priority matching
// each scan walks all ORDER_SLOTS slots one per cycle; a result then waits for the output register to be free
// a new order runs one scan per fill plus a final scan, a cancel a single scan
// the next beat is taken once the final result has been taken
// synchronous active-low reset empties the book and clears the arrival count
module limit_order_book_matcher import lobm_pkg::*; #(
    parameter int ORDER_SLOTS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_operation,
    input  logic        i_side,
    input  logic [31:0] i_order_id,
    input  logic [15:0] i_limit_price,
    input  logic [15:0] i_quantity,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_kind,
    output logic [31:0] o_maker_id,
    output logic [15:0] o_fill_quantity,
    output logic [15:0] o_fill_price,
    output logic [15:0] o_remaining,
    output logic        o_last
);
    t_cmd    w_cmd;
    t_status w_status;

    lobm_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready,
        .i_status(w_status), .o_cmd(w_cmd)
    );

    lobm_datapath #(.ORDER_SLOTS(ORDER_SLOTS)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .o_status(w_status),
        .i_operation, .i_side, .i_order_id, .i_limit_price, .i_quantity,
        .o_kind, .o_maker_id, .o_fill_quantity, .o_fill_price, .o_remaining, .o_last
    );
endmodule

/* src/lobm_datapath.sv */
// slot table, scan unit and result register
module lobm_datapath import lobm_pkg::*; #(
    parameter int ORDER_SLOTS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    input  logic [1:0]  i_operation,
    input  logic        i_side,
    input  logic [31:0] i_order_id,
    input  logic [15:0] i_limit_price,
    input  logic [15:0] i_quantity,
    output logic [2:0]  o_kind,
    output logic [31:0] o_maker_id,
    output logic [15:0] o_fill_quantity,
    output logic [15:0] o_fill_price,
    output logic [15:0] o_remaining,
    output logic        o_last
);
    localparam int IW = $clog2(ORDER_SLOTS);
    localparam int CW = $clog2(ORDER_SLOTS + 1);

    logic [ORDER_SLOTS-1:0] r_valid;
    logic                   r_sside [ORDER_SLOTS];
    logic [15:0]            r_sprice[ORDER_SLOTS];
    logic [15:0]            r_sqty  [ORDER_SLOTS];
    logic [31:0]            r_sid   [ORDER_SLOTS];
    logic [31:0]            r_sseq  [ORDER_SLOTS];
    logic [31:0]            r_arrival;

    logic [1:0]  r_op;
    logic        r_side;
    logic [31:0] r_id;
    logic [15:0] r_limit;
    logic [15:0] r_qty;
    logic [15:0] r_rem;

    logic [CW-1:0] r_idx;
    logic          r_found;
    logic [IW-1:0] r_best;
    logic [31:0]   r_best_age;
    logic [15:0]   r_best_price;
    logic          r_has_free;
    logic [IW-1:0] r_free;

    logic [IW-1:0] w_i;
    logic [31:0]   w_age;
    logic [15:0]   w_p;
    logic          w_cand, w_better;
    logic [15:0]   w_sq, w_traded, w_taken;

    assign w_i   = r_idx[IW-1:0];
    assign w_age = r_arrival - r_sseq[w_i];
    assign w_p   = r_sprice[w_i];

    always_comb begin
        if (r_op != OP_NEW) begin
            w_cand   = r_valid[w_i] && r_sside[w_i] == r_side && r_sid[w_i] == r_id;
            w_better = !r_found || w_age > r_best_age;
        end else begin
            w_cand   = r_valid[w_i] && r_sside[w_i] != r_side &&
                       (r_side ? (w_p <= r_limit) : (w_p >= r_limit));
            w_better = !r_found || (r_side ? (w_p < r_best_price) : (w_p > r_best_price)) ||
                       (w_p == r_best_price && w_age > r_best_age);
        end
    end

    assign w_sq     = r_sqty[r_best];
    assign w_traded = (w_sq < r_rem) ? w_sq : r_rem;
    assign w_taken  = (r_op == OP_TOTAL || r_qty >= w_sq) ? w_sq : r_qty;

    assign o_status.scan_done = (r_idx == CW'(ORDER_SLOTS));
    assign o_status.found     = r_found;
    assign o_status.has_free  = r_has_free;
    assign o_status.rem_zero  = (r_rem == 16'd0);
    assign o_status.operation = r_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_arrival <= '0;
            r_idx     <= '0;
            r_found   <= 1'b0;
            r_has_free <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_op    <= i_operation;
                r_side  <= i_side;
                r_id    <= i_order_id;
                r_limit <= i_limit_price;
                r_qty   <= i_quantity;
                r_rem   <= i_quantity;
            end
            if (i_cmd.scan_clear) begin
                r_idx      <= '0;
                r_found    <= 1'b0;
                r_has_free <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_idx <= r_idx + 1'b1;
                if (w_cand && w_better) begin
                    r_found      <= 1'b1;
                    r_best       <= w_i;
                    r_best_age   <= w_age;
                    r_best_price <= w_p;
                end
                // lowest free slot
                if (!r_valid[w_i] && !r_has_free) begin
                    r_has_free <= 1'b1;
                    r_free     <= w_i;
                end
            end
            if (i_cmd.do_fill) begin
                r_rem          <= r_rem - w_traded;
                r_sqty[r_best] <= w_sq - w_traded;
                if (w_sq == w_traded) r_valid[r_best] <= 1'b0;
            end
            if (i_cmd.do_cancel) begin
                r_sqty[r_best] <= w_sq - w_taken;
                if (w_sq == w_taken) r_valid[r_best] <= 1'b0;
            end
            if (i_cmd.do_rest) begin
                r_valid[r_free]  <= 1'b1;
                r_sside[r_free]  <= r_side;
                r_sprice[r_free] <= r_limit;
                r_sqty[r_free]   <= r_rem;
                r_sid[r_free]    <= r_id;
                r_sseq[r_free]   <= r_arrival;
            end
            // arrival count moves once per new order, at its closing result
            if (i_cmd.out_load && i_cmd.out_last && r_op == OP_NEW) begin
                r_arrival <= r_arrival + 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_kind          <= i_cmd.out_kind;
            o_last          <= i_cmd.out_last;
            o_maker_id      <= '0;
            o_fill_quantity <= '0;
            o_fill_price    <= '0;
            o_remaining     <= '0;
            unique case (i_cmd.out_kind)
                KIND_FILL: begin
                    o_maker_id      <= r_sid[r_best];
                    o_fill_quantity <= w_traded;
                    o_fill_price    <= r_sprice[r_best];
                    o_remaining     <= r_rem - w_traded;
                end
                KIND_RESTED: begin
                    o_maker_id   <= r_id;
                    o_fill_price <= r_limit;
                    o_remaining  <= r_rem;
                end
                KIND_CANCELED: begin
                    o_maker_id      <= r_id;
                    o_fill_quantity <= w_taken;
                    o_fill_price    <= r_sprice[r_best];
                    o_remaining     <= w_sq - w_taken;
                end
                default: ;
            endcase
        end
    end
endmodule

/* src/lobm_ctrl.sv */
// sequencing of scans, fills, rests and cancels
module lobm_ctrl import lobm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_DECIDE, ST_OUT} t_state;
    t_state r_state, n_state;
    logic   r_valid, n_valid;

    assign o_ready = (r_state == ST_IDLE) && !r_valid;
    assign o_valid = r_valid;

    always_comb begin
        n_state = r_state;
        n_valid = r_valid;
        o_cmd   = '0;
        if (r_valid && i_ready) n_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid && o_ready) begin
                    o_cmd.load       = 1'b1;
                    o_cmd.scan_clear = 1'b1;
                    n_state          = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_status.scan_done) n_state = ST_DECIDE;
                else o_cmd.scan_step = 1'b1;
            end
            ST_DECIDE: begin
                if (!r_valid || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_valid        = 1'b1;
                    n_state        = ST_IDLE;
                    o_cmd.out_last = 1'b1;
                    if (i_status.operation == OP_NEW) begin
                        if (i_status.rem_zero) begin
                            o_cmd.out_kind = KIND_FILLED;
                        end else if (i_status.found) begin
                            o_cmd.out_kind   = KIND_FILL;
                            o_cmd.out_last   = 1'b0;
                            o_cmd.do_fill    = 1'b1;
                            o_cmd.scan_clear = 1'b1;
                            n_state          = ST_SCAN;
                        end else if (i_status.has_free) begin
                            o_cmd.out_kind = KIND_RESTED;
                            o_cmd.do_rest  = 1'b1;
                        end else begin
                            o_cmd.out_kind = KIND_FULL;
                        end
                    end else if ((i_status.operation == OP_PARTIAL ||
                                  i_status.operation == OP_TOTAL) && i_status.found) begin
                        o_cmd.out_kind  = KIND_CANCELED;
                        o_cmd.do_cancel = 1'b1;
                    end else begin
                        o_cmd.out_kind = KIND_NOT_FOUND;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end
endmodule
